### rtl/fucr_pkg.sv
// Shared constants, codes and transaction types for the firmware chunk receiver.
package fucr_pkg;

  // Chunk payload size and the reciprocal used for the last-chunk remainder
  localparam int          CHUNK_BYTES = 192;
  localparam logic [32:0] CHUNK_RECIP = 33'((65'd1 << 32) / CHUNK_BYTES);

  localparam logic [7:0]  MIN_PACKET   = 8'd3;
  localparam logic [7:0]  MIN_ANNOUNCE = 8'd12;
  localparam logic [7:0]  MIN_CHUNK    = 8'd8;

  localparam logic [23:0] IDLE_MAX      = 24'hFFFFFF;
  localparam logic [23:0] TIMEOUT_RESET = 24'd60000;

  // Incoming command codes
  localparam logic [2:0] CMD_ANNOUNCE = 3'd0;
  localparam logic [2:0] CMD_CHUNK    = 3'd1;
  localparam logic [2:0] CMD_QUERY    = 3'd2;
  localparam logic [2:0] CMD_COMPLETE = 3'd3;
  localparam logic [2:0] CMD_ABORT    = 3'd4;
  localparam logic [2:0] CMD_TICK     = 3'd5;

  // Classified operations handed from front to back
  localparam logic [3:0] OP_ACTIVITY   = 4'd0;
  localparam logic [3:0] OP_TICK       = 4'd1;
  localparam logic [3:0] OP_ANN_LATEST = 4'd2;
  localparam logic [3:0] OP_ANN_FAIL   = 4'd3;
  localparam logic [3:0] OP_ANN_START  = 4'd4;
  localparam logic [3:0] OP_CHUNK      = 4'd5;
  localparam logic [3:0] OP_QUERY      = 4'd6;
  localparam logic [3:0] OP_COMPLETE   = 4'd7;
  localparam logic [3:0] OP_ABORT      = 4'd8;

  // Transfer phase
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_RECV = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  // Reply kinds and answered-command codes
  localparam logic [1:0] KIND_ACK    = 2'd0;
  localparam logic [1:0] KIND_NACK   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [1:0] ACK_ANNOUNCE = 2'd0;
  localparam logic [1:0] ACK_CHUNK    = 2'd1;
  localparam logic [1:0] ACK_COMPLETE = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_LATEST = 3'd1;
  localparam logic [2:0] ST_FLASH  = 3'd2;
  localparam logic [2:0] ST_SEQ    = 3'd3;
  localparam logic [2:0] ST_LEN    = 3'd4;
  localparam logic [2:0] ST_CRC    = 3'd5;
  localparam logic [2:0] ST_SIZE   = 3'd6;

  // Command queue between front and back
  localparam int CQ_DEPTH = 4;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);
  localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

  // Reply queue at the back
  localparam int OQ_DEPTH = 2;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    logic [3:0]  op;
    logic        short_chunk;
    logic        crc_ok;
    logic        flash_ok;
    logic [31:0] image_size;
    logic [15:0] chunk_count;
    logic [15:0] chunk_seq;
    logic [7:0]  chunk_len;
    logic [7:0]  tail;
  } item_t;

  typedef struct packed {
    logic [1:0]  reply_kind;
    logic [1:0]  acked_command;
    logic [15:0] reply_seq;
    logic [2:0]  status_code;
    logic [1:0]  node_phase;
  } reply_t;

endpackage

### rtl/fucr_front.sv
// Front end: packet classification, last-chunk remainder and command queue.
module fucr_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [2:0]           in_command,
  input  logic [7:0]           in_packet_len,
  input  logic                 in_target_match,
  input  logic                 in_version_same,
  input  logic                 in_flash_ok,
  input  logic [31:0]          in_image_size,
  input  logic [15:0]          in_chunk_count,
  input  logic [15:0]          in_chunk_seq,
  input  logic [7:0]           in_chunk_len,
  input  logic                 in_crc_ok,
  output logic                 q_valid,
  output fucr_pkg::item_t      q_item,
  input  logic                 q_pop
);

  logic                    accept;
  logic                    runt;
  fucr_pkg::item_t         cls_item;
  logic [64:0]             prod;

  logic                    s1_v_r;
  fucr_pkg::item_t         s1_item_r;
  logic [8:0]              s1_qlo_r;

  logic [8:0]              qc_lo;
  logic [8:0]              rem0;
  fucr_pkg::item_t         push_item;

  fucr_pkg::item_t         cq_mem_r [fucr_pkg::CQ_DEPTH];
  logic [fucr_pkg::CQ_AW-1:0] cq_wp_r, cq_wp_nxt;
  logic [fucr_pkg::CQ_AW-1:0] cq_rp_r, cq_rp_nxt;
  logic [fucr_pkg::CQ_CW-1:0] cq_cnt_r, cq_cnt_nxt;
  logic [fucr_pkg::CQ_CW:0]   occ;
  logic                    do_pop;

  // Credit: the item in the stage register already owns a queue slot
  assign occ     = {1'b0, cq_cnt_r} + {{fucr_pkg::CQ_CW{1'b0}}, s1_v_r};
  assign in_full = occ >= (fucr_pkg::CQ_CW+1)'(fucr_pkg::CQ_DEPTH);

  assign runt   = (in_command != fucr_pkg::CMD_TICK) && (in_packet_len < fucr_pkg::MIN_PACKET);
  assign accept = in_push && !in_full && !runt;

  assign prod = 65'(in_image_size) * 65'(fucr_pkg::CHUNK_RECIP);

  always_comb begin
    cls_item             = '0;
    cls_item.short_chunk = in_packet_len < fucr_pkg::MIN_CHUNK;
    cls_item.crc_ok      = in_crc_ok;
    cls_item.flash_ok    = in_flash_ok;
    cls_item.image_size  = in_image_size;
    cls_item.chunk_count = in_chunk_count;
    cls_item.chunk_seq   = in_chunk_seq;
    cls_item.chunk_len   = in_chunk_len;
    unique case (in_command)
      fucr_pkg::CMD_ANNOUNCE: begin
        if (in_packet_len < fucr_pkg::MIN_ANNOUNCE || !in_target_match) begin
          cls_item.op = fucr_pkg::OP_ACTIVITY;
        end else if (in_version_same) begin
          cls_item.op = fucr_pkg::OP_ANN_LATEST;
        end else if (!in_flash_ok) begin
          cls_item.op = fucr_pkg::OP_ANN_FAIL;
        end else begin
          cls_item.op = fucr_pkg::OP_ANN_START;
        end
      end
      fucr_pkg::CMD_CHUNK:    cls_item.op = fucr_pkg::OP_CHUNK;
      fucr_pkg::CMD_QUERY:    cls_item.op = fucr_pkg::OP_QUERY;
      fucr_pkg::CMD_COMPLETE: cls_item.op = fucr_pkg::OP_COMPLETE;
      fucr_pkg::CMD_ABORT:    cls_item.op = fucr_pkg::OP_ABORT;
      fucr_pkg::CMD_TICK:     cls_item.op = fucr_pkg::OP_TICK;
      default:                cls_item.op = fucr_pkg::OP_ACTIVITY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
    end
    if (accept) begin
      s1_item_r <= cls_item;
      s1_qlo_r  <= prod[40:32];
    end
  end

  // Quotient estimate is low by at most one, so remainder is below 2*CHUNK_BYTES
  // and fits in nine bits; one conditional subtract finishes it.
  assign qc_lo = 9'(s1_qlo_r * 9'(fucr_pkg::CHUNK_BYTES));
  assign rem0  = s1_item_r.image_size[8:0] - qc_lo;

  always_comb begin
    push_item = s1_item_r;
    if (rem0 >= 9'(fucr_pkg::CHUNK_BYTES)) begin
      push_item.tail = 8'(rem0 - 9'(fucr_pkg::CHUNK_BYTES));
    end else begin
      push_item.tail = 8'(rem0);
    end
  end

  assign q_valid = cq_cnt_r != '0;
  assign q_item  = cq_mem_r[cq_rp_r];
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    cq_wp_nxt  = s1_v_r ? cq_wp_r + 1'b1 : cq_wp_r;
    cq_rp_nxt  = do_pop ? cq_rp_r + 1'b1 : cq_rp_r;
    cq_cnt_nxt = cq_cnt_r + fucr_pkg::CQ_CW'(s1_v_r) - fucr_pkg::CQ_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cq_wp_r  <= '0;
      cq_rp_r  <= '0;
      cq_cnt_r <= '0;
    end else begin
      cq_wp_r  <= cq_wp_nxt;
      cq_rp_r  <= cq_rp_nxt;
      cq_cnt_r <= cq_cnt_nxt;
    end
    if (s1_v_r) begin
      cq_mem_r[cq_wp_r] <= push_item;
    end
  end

endmodule

### rtl/fucr_back.sv
// Back end: transfer state, per-operation decisions and reply queue.
module fucr_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [23:0]          cfg_timeout_ticks,
  input  logic                 q_valid,
  input  fucr_pkg::item_t      q_item,
  output logic                 q_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output fucr_pkg::reply_t     out_reply
);

  logic [23:0] timeout_r;
  logic [1:0]  phase_r, phase_nxt;
  logic [31:0] total_size_r, total_size_nxt;
  logic [15:0] total_chunks_r, total_chunks_nxt;
  logic [7:0]  tail_r, tail_nxt;
  logic [15:0] exp_seq_r, exp_seq_nxt;
  logic [31:0] bytes_r, bytes_nxt;
  logic [23:0] idle_r, idle_nxt;

  logic [23:0] idle_inc;
  logic        last_chunk;
  logic [7:0]  want_len;
  logic        exec;
  logic        rep_v;
  fucr_pkg::reply_t rep;

  fucr_pkg::reply_t           oq_mem_r [fucr_pkg::OQ_DEPTH];
  logic [fucr_pkg::OQ_AW-1:0] oq_wp_r, oq_rp_r;
  logic [fucr_pkg::OQ_CW-1:0] oq_cnt_r;
  logic                       oq_pop;
  logic                       room;

  assign oq_pop    = out_pop && !out_empty;
  assign out_empty = oq_cnt_r == '0;
  assign out_reply = oq_mem_r[oq_rp_r];
  assign room      = (oq_cnt_r != fucr_pkg::OQ_CW'(fucr_pkg::OQ_DEPTH)) || oq_pop;
  assign exec      = q_valid && room;
  assign q_pop     = exec;

  assign idle_inc   = (idle_r == fucr_pkg::IDLE_MAX) ? idle_r : idle_r + 24'd1;
  assign last_chunk = (total_chunks_r != '0) && (q_item.chunk_seq == total_chunks_r - 16'd1)
                      && (tail_r != '0);
  assign want_len   = last_chunk ? tail_r : 8'(fucr_pkg::CHUNK_BYTES);

  always_comb begin
    phase_nxt        = phase_r;
    total_size_nxt   = total_size_r;
    total_chunks_nxt = total_chunks_r;
    tail_nxt         = tail_r;
    exp_seq_nxt      = exp_seq_r;
    bytes_nxt        = bytes_r;
    idle_nxt         = idle_r;
    rep_v            = 1'b0;
    rep              = '0;
    if (exec) begin
      if (q_item.op != fucr_pkg::OP_TICK) begin
        idle_nxt = '0;
      end
      unique case (q_item.op)
        fucr_pkg::OP_TICK: begin
          idle_nxt = idle_inc;
          if (phase_r == fucr_pkg::PH_RECV && idle_inc > timeout_r) begin
            phase_nxt   = fucr_pkg::PH_IDLE;
            exp_seq_nxt = '0;
          end
        end
        fucr_pkg::OP_ANN_LATEST: begin
          rep_v            = 1'b1;
          rep.reply_kind   = fucr_pkg::KIND_NACK;
          rep.acked_command = fucr_pkg::ACK_ANNOUNCE;
          rep.status_code  = fucr_pkg::ST_LATEST;
        end
        fucr_pkg::OP_ANN_FAIL: begin
          phase_nxt        = fucr_pkg::PH_IDLE;
          rep_v            = 1'b1;
          rep.reply_kind   = fucr_pkg::KIND_NACK;
          rep.acked_command = fucr_pkg::ACK_ANNOUNCE;
          rep.status_code  = fucr_pkg::ST_FLASH;
        end
        fucr_pkg::OP_ANN_START: begin
          total_size_nxt   = q_item.image_size;
          total_chunks_nxt = q_item.chunk_count;
          tail_nxt         = q_item.tail;
          exp_seq_nxt      = '0;
          bytes_nxt        = '0;
          phase_nxt        = fucr_pkg::PH_RECV;
          rep_v            = 1'b1;
          rep.reply_kind   = fucr_pkg::KIND_ACK;
          rep.acked_command = fucr_pkg::ACK_ANNOUNCE;
          rep.status_code  = fucr_pkg::ST_OK;
        end
        fucr_pkg::OP_CHUNK: begin
          if (phase_r == fucr_pkg::PH_RECV) begin
            rep_v             = 1'b1;
            rep.acked_command = fucr_pkg::ACK_CHUNK;
            rep.reply_seq     = q_item.chunk_seq;
            rep.reply_kind    = fucr_pkg::KIND_NACK;
            if (q_item.short_chunk) begin
              rep.reply_seq   = exp_seq_r;
              rep.status_code = fucr_pkg::ST_SEQ;
            end else if (q_item.chunk_len != want_len) begin
              rep.status_code = fucr_pkg::ST_LEN;
            end else if (!q_item.crc_ok) begin
              rep.status_code = fucr_pkg::ST_CRC;
            end else if (q_item.chunk_seq == exp_seq_r) begin
              if (!q_item.flash_ok) begin
                rep.status_code = fucr_pkg::ST_FLASH;
              end else begin
                exp_seq_nxt     = exp_seq_r + 16'd1;
                bytes_nxt       = bytes_r + {24'd0, q_item.chunk_len};
                rep.reply_kind  = fucr_pkg::KIND_ACK;
                rep.status_code = fucr_pkg::ST_OK;
              end
            end else if (q_item.chunk_seq < exp_seq_r) begin
              // duplicate: ack again
              rep.reply_kind  = fucr_pkg::KIND_ACK;
              rep.status_code = fucr_pkg::ST_OK;
            end else begin
              rep.status_code = fucr_pkg::ST_SEQ;
            end
          end
        end
        fucr_pkg::OP_QUERY: begin
          rep_v          = 1'b1;
          rep.reply_kind = fucr_pkg::KIND_STATUS;
          rep.reply_seq  = exp_seq_r;
          rep.node_phase = phase_r;
        end
        fucr_pkg::OP_COMPLETE: begin
          if (phase_r == fucr_pkg::PH_RECV) begin
            rep_v             = 1'b1;
            rep.acked_command = fucr_pkg::ACK_COMPLETE;
            rep.reply_seq     = total_chunks_r;
            if (bytes_r != total_size_r) begin
              phase_nxt       = fucr_pkg::PH_IDLE;
              exp_seq_nxt     = '0;
              rep.reply_kind  = fucr_pkg::KIND_NACK;
              rep.status_code = fucr_pkg::ST_SIZE;
            end else if (q_item.flash_ok) begin
              phase_nxt       = fucr_pkg::PH_DONE;
              rep.reply_kind  = fucr_pkg::KIND_ACK;
              rep.status_code = fucr_pkg::ST_OK;
            end else begin
              phase_nxt       = fucr_pkg::PH_IDLE;
              exp_seq_nxt     = '0;
              rep.reply_kind  = fucr_pkg::KIND_NACK;
              rep.status_code = fucr_pkg::ST_FLASH;
            end
          end
        end
        fucr_pkg::OP_ABORT: begin
          phase_nxt   = fucr_pkg::PH_IDLE;
          exp_seq_nxt = '0;
        end
        default: begin
          // plain activity: idle count already cleared
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r      <= fucr_pkg::TIMEOUT_RESET;
      phase_r        <= fucr_pkg::PH_IDLE;
      total_size_r   <= '0;
      total_chunks_r <= '0;
      tail_r         <= '0;
      exp_seq_r      <= '0;
      bytes_r        <= '0;
      idle_r         <= '0;
      oq_wp_r        <= '0;
      oq_rp_r        <= '0;
      oq_cnt_r       <= '0;
    end else begin
      if (cfg_we) begin
        timeout_r <= cfg_timeout_ticks;
      end
      phase_r        <= phase_nxt;
      total_size_r   <= total_size_nxt;
      total_chunks_r <= total_chunks_nxt;
      tail_r         <= tail_nxt;
      exp_seq_r      <= exp_seq_nxt;
      bytes_r        <= bytes_nxt;
      idle_r         <= idle_nxt;
      if (rep_v) begin
        oq_wp_r <= oq_wp_r + 1'b1;
      end
      if (oq_pop) begin
        oq_rp_r <= oq_rp_r + 1'b1;
      end
      oq_cnt_r <= oq_cnt_r + fucr_pkg::OQ_CW'(rep_v) - fucr_pkg::OQ_CW'(oq_pop);
    end
    if (rep_v) begin
      oq_mem_r[oq_wp_r] <= rep;
    end
  end

endmodule

### rtl/firmware_update_chunk_receiver_top.sv
// Top level of the firmware update chunk receiver: front end, back end, assertions.
// Usage:
//   Input channel: drive a decoded packet or a tick on the in_ ports with in_push;
//   the transaction is taken on a rising edge with in_push high and in_full low.
//   Runt packets (non-tick, shorter than three bytes) are dropped on entry.
//   Result channel: while out_empty is low the oldest reply sits on the out_ ports;
//   raise out_pop to take it. Packets that earn no reply produce nothing here.
//   Config: cfg_we with cfg_timeout_ticks loads the idle timeout; write it only
//   while no transaction is in flight.
// Timing:
//   One transaction per cycle sustained while out_pop keeps the reply queue draining.
//   A reply passes the remainder stage (32x33 multiply), then the command queue,
//   where the back end decides as it pops the command, then the reply queue.
//   A four-entry command queue separates classification from execution, and a
//   two-entry reply queue separates execution from the consumer.
// Stall / reset:
//   If out_pop is held low, the reply queue fills, the back end stops, and the
//   command queue fills; in_full then rises and holds until replies drain.
//   Synchronous reset (rst_n low) empties both queues, sets the phase to idle,
//   clears counters and loads the default timeout of 60000 ticks.
module firmware_update_chunk_receiver_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [2:0]  in_command,
  input  logic [7:0]  in_packet_len,
  input  logic        in_target_match,
  input  logic        in_version_same,
  input  logic        in_flash_ok,
  input  logic [31:0] in_image_size,
  input  logic [15:0] in_chunk_count,
  input  logic [15:0] in_chunk_seq,
  input  logic [7:0]  in_chunk_len,
  input  logic        in_crc_ok,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_reply_kind,
  output logic [1:0]  out_acked_command,
  output logic [15:0] out_reply_seq,
  output logic [2:0]  out_status_code,
  output logic [1:0]  out_node_phase,
  input  logic        cfg_we,
  input  logic [23:0] cfg_timeout_ticks
);

  logic             q_valid;
  logic             q_pop;
  fucr_pkg::item_t  q_item;
  fucr_pkg::reply_t out_reply;

  fucr_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_command      (in_command),
    .in_packet_len   (in_packet_len),
    .in_target_match (in_target_match),
    .in_version_same (in_version_same),
    .in_flash_ok     (in_flash_ok),
    .in_image_size   (in_image_size),
    .in_chunk_count  (in_chunk_count),
    .in_chunk_seq    (in_chunk_seq),
    .in_chunk_len    (in_chunk_len),
    .in_crc_ok       (in_crc_ok),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  fucr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_timeout_ticks (cfg_timeout_ticks),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_reply         (out_reply)
  );

  assign out_reply_kind    = out_reply.reply_kind;
  assign out_acked_command = out_reply.acked_command;
  assign out_reply_seq     = out_reply.reply_seq;
  assign out_status_code   = out_reply.status_code;
  assign out_node_phase    = out_reply.node_phase;

`ifndef ASSERT_OFF
  // Both queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // Back end only takes a command the queue actually holds
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("command queue popped while empty");

  // Status reports carry no command or status code; acks and nacks carry no phase
  a_status_fields: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> ((out_reply_kind == fucr_pkg::KIND_STATUS)
                    ? (out_status_code == fucr_pkg::ST_OK && out_acked_command == 2'd0)
                    : (out_node_phase == fucr_pkg::PH_IDLE)))
    else $error("reply fields inconsistent with reply kind");

  // A waiting reply holds still until it is taken
  a_reply_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_reply))
    else $error("waiting reply changed before pop");
`endif

endmodule
